// ----- hdl/rslot_pkg.sv -----
// Shared types and constants for the record slot table.
package rslot_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int CODE_W        = 16;
  localparam int SLOT_W        = 4;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

endpackage

// ----- hdl/rslot_if.sv -----
// Request and response channel interfaces of the record slot table.
interface rslot_in_if import rslot_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [CODE_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface rslot_out_if import rslot_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot;
  logic [CODE_W-1:0] entry_code;
  logic              any_active;

  modport source (output valid, output status, output slot, output entry_code,
                  output any_active, input ready);
  modport sink   (input valid, input status, input slot, input entry_code,
                  input any_active, output ready);
endinterface

// ----- hdl/record_slot_table.sv -----
// Top level of the record slot table: slot scan, allocation and code lookup.
//
//   channel | direction | payload
//   --------+-----------+--------------------------------------------
//   req     | in        | opcode[1:0], key[15:0]
//   rsp     | out       | status[1:0], slot[3:0], entry_code[15:0], any_active
//
// Each transaction scans every slot between acceptance and the next acceptance, paced
// by the slot RAM's single read port scanning one slot per cycle. After reset a
// clearing pass writes every slot; no request is taken until it ends. The result sits
// in an output register; a new request is accepted while it waits, and only the
// write-back step stalls until the register is free.
module record_slot_table import rslot_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  rslot_in_if.sink    req,
  rslot_out_if.source rsp
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MW = CODE_W + 1;
  localparam logic [CW-1:0] LAST_IDX  = CW'(SLOTS);
  localparam logic [CW-1:0] CLEAR_END = CW'(SLOTS - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t            state;
  logic [CW-1:0]     idx;
  logic [1:0]        op;
  logic [CODE_W-1:0] key_q;
  logic              free_found;
  logic [AW-1:0]     free_idx;
  logic              match_found;
  logic [AW-1:0]     match_idx;
  logic [CODE_W-1:0] top;
  logic [CW-1:0]     active_cnt;

  logic              rsp_valid;
  logic [1:0]        rsp_status;
  logic [SLOT_W-1:0] rsp_slot;
  logic [CODE_W-1:0] rsp_code;
  logic              rsp_any;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [MW-1:0]     wdata;
  logic [AW-1:0]     raddr;
  logic [MW-1:0]     rdata;
  logic              rd_active;
  logic [CODE_W-1:0] rd_code;
  logic [AW-1:0]     proc_idx;

  logic              fin_go;
  logic [1:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [CODE_W-1:0] res_code;
  logic [CW-1:0]     cnt_next;

  rslot_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign raddr     = idx[AW-1:0];
  assign rd_active = rdata[MW-1];
  assign rd_code   = rdata[CODE_W-1:0];
  // Data returning now belongs to the slot addressed in the cycle before.
  assign proc_idx  = AW'(idx - CW'(1));

  assign fin_go = (state == S_FINISH) && (!rsp_valid || rsp.ready);

  always_comb begin
    res_status = ST_NOTFOUND;
    res_slot   = '0;
    res_code   = '0;
    cnt_next   = active_cnt;
    we         = 1'b0;
    waddr      = free_idx;
    wdata      = '0;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = idx[AW-1:0];
    end else if (state == S_FINISH) begin
      case (op) inside
        OP_ADD: begin
          if (!free_found) begin
            res_status = ST_FULL;
          end else if (top == CODE_MAX) begin
            res_status = ST_OVERFLOW;
          end else begin
            res_status = ST_OK;
            res_slot   = SLOT_W'(free_idx);
            res_code   = top + CODE_W'(1);
            cnt_next   = active_cnt + CW'(1);
            we         = fin_go;
            waddr      = free_idx;
            wdata      = {1'b1, res_code};
          end
        end
        OP_REMOVE, OP_FIND: begin
          if (match_found) begin
            res_status = ST_OK;
            res_slot   = SLOT_W'(match_idx);
            res_code   = key_q;
            if (op == OP_REMOVE) begin
              cnt_next = active_cnt - CW'(1);
              we       = fin_go;
              waddr    = match_idx;
              wdata    = {1'b0, key_q};
            end
          end
        end
        default: begin
          res_status = ST_NOTFOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      active_cnt <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (fin_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx == CLEAR_END) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op          <= req.opcode;
            key_q       <= req.key;
            free_found  <= 1'b0;
            match_found <= 1'b0;
            top         <= '0;
            idx         <= '0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx <= idx + CW'(1);
          if (idx != '0) begin
            if (!rd_active && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= proc_idx;
            end
            if (rd_active && rd_code > top) begin
              top <= rd_code;
            end
            if (rd_active && rd_code == key_q && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= proc_idx;
            end
          end
          if (idx == LAST_IDX) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            rsp_status <= res_status;
            rsp_slot   <= res_slot;
            rsp_code   <= res_code;
            rsp_any    <= (cnt_next != '0);
            active_cnt <= cnt_next;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.slot       = rsp_slot;
  assign rsp.entry_code = rsp_code;
  assign rsp.any_active = rsp_any;

  // The active count can never pass the number of slots.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    active_cnt <= LAST_IDX)
    else $error("active slot count exceeds table size");

  // A waiting result always agrees with the live active count.
  a_any_consistent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_any == (active_cnt != '0)))
    else $error("any_active disagrees with active count");

  // A new result is only ever produced by the write-back step.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !$past(rsp_valid)) |-> $past(state == S_FINISH))
    else $error("result loaded outside write-back");

  // The RAM is never written while a scan is reading it.
  a_no_scan_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !we)
    else $error("slot RAM written during scan");

endmodule

// ----- hdl/rslot_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module rslot_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
